/* rtl/wbps_pkg.sv */
// Shared constants and types of the wildcard byte pattern scanner.
package wbps_pkg;

  localparam int PATTERN_MAX = 64;
  localparam int OFFSET_BITS = 32;

  localparam int LEN_W    = 7;
  localparam int IDX_W    = 6;
  localparam int BYTE_W   = 8;
  localparam int RESULT_W = 32;
  localparam int SHIFT_W  = $clog2(PATTERN_MAX + 1);

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  typedef logic [BYTE_W-1:0] byte_t;

endpackage

/* rtl/wbps_match.sv */
// Window against pattern comparator: aligns the window to the pattern length and checks the lanes below it.
module wbps_match import wbps_pkg::*; (
  input  byte_t            win [PATTERN_MAX],
  input  byte_t            pat_val [PATTERN_MAX],
  input  logic             pat_wild [PATTERN_MAX],
  input  logic [LEN_W-1:0] len,
  output logic             hit
);

  logic [PATTERN_MAX*BYTE_W-1:0] rev;
  logic [PATTERN_MAX*BYTE_W-1:0] aligned;
  logic [SHIFT_W-1:0]            shamt;
  logic [PATTERN_MAX-1:0]        lane_ok;

  // lane j of aligned holds win[len-1-j]
  always_comb begin
    for (int k = 0; k < PATTERN_MAX; k++) begin
      rev[k*BYTE_W +: BYTE_W] = win[PATTERN_MAX-1-k];
    end
    shamt   = SHIFT_W'(PATTERN_MAX) - SHIFT_W'(len);
    aligned = rev >> {shamt, 3'b000};
    for (int j = 0; j < PATTERN_MAX; j++) begin
      lane_ok[j] = pat_wild[j] || (aligned[j*BYTE_W +: BYTE_W] == pat_val[j]) ||
                   (SHIFT_W'(j) >= SHIFT_W'(len));
    end
    hit = &lane_ok;
  end

endmodule

/* rtl/wildcard_byte_pattern_scanner_top.sv */
// Top level of the wildcard byte pattern scanner.
//
//  channel  dir  handshake           payload
//  s        in   s_tvalid/s_tready   tuser command, tdata load/scan fields, tlast region_end
//  m        out  m_tvalid/m_tready   tuser match_found, tdata match_offset
//  cfg      in   cfg_valid/cfg_ready cfg_data pattern_length
//
// One item per cycle sustained unless the output stalls; an item waits in the input register
// and any result goes to the output register as it leaves. The whole window compare is one
// pass of parallel comparators after a barrel alignment on the pattern length.
// rst clears control state and the counters; pattern and window storage are not reset.
// A stalled result holds the output register; the input register keeps taking items
// while the output register is free or being taken.
module wildcard_byte_pattern_scanner_top import wbps_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,   // pattern_index[5:0], pattern_value[13:6],
                                         // pattern_wild[14], data_byte[22:15], zero[23]
  input  logic [0:0]          s_tuser,   // command[0]
  input  logic                s_tlast,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [RESULT_W-1:0] m_tdata,   // match_offset[31:0]
  output logic [0:0]          m_tuser,   // match_found[0]
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [LEN_W-1:0]    cfg_data
);

  logic                   in_valid;
  cmd_t                   in_cmd;
  logic [IDX_W-1:0]       in_idx;
  byte_t                  in_val;
  logic                   in_wild;
  byte_t                  in_byte;
  logic                   in_last;

  byte_t                  window [PATTERN_MAX];
  byte_t                  window_next [PATTERN_MAX];
  byte_t                  pat_val [PATTERN_MAX];
  logic                   pat_wild [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic [OFFSET_BITS-1:0] bytes_seen_next;
  logic                   hit_reported;
  logic [LEN_W-1:0]       pattern_length;
  logic [LEN_W-1:0]       len_eff;

  logic                   out_valid;
  logic                   out_found;
  logic [RESULT_W-1:0]    out_offset;

  logic                   proc;
  logic                   scan;
  logic                   win_hit;
  logic                   hit;
  logic                   miss;
  logic [OFFSET_BITS-1:0] offset_full;

  assign proc      = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || proc;
  assign cfg_ready = 1'b1;
  assign scan      = proc && (in_cmd == CMD_SCAN);

  assign len_eff = (int'(pattern_length) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX) : pattern_length;

  always_comb begin
    window_next[0] = in_byte;
    for (int k = 1; k < PATTERN_MAX; k++) begin
      window_next[k] = window[k-1];
    end
    bytes_seen_next = (bytes_seen == {OFFSET_BITS{1'b1}}) ? bytes_seen :
                      bytes_seen + OFFSET_BITS'(1);
  end

  wbps_match u_match (
    .win      (window_next),
    .pat_val  (pat_val),
    .pat_wild (pat_wild),
    .len      (len_eff),
    .hit      (win_hit)
  );

  assign hit  = !hit_reported && (len_eff != '0) &&
                (bytes_seen_next >= OFFSET_BITS'(len_eff)) && win_hit;
  assign miss = !hit && in_last && !hit_reported;
  assign offset_full = bytes_seen_next - OFFSET_BITS'(len_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid       <= 1'b0;
      out_valid      <= 1'b0;
      bytes_seen     <= '0;
      hit_reported   <= 1'b0;
      pattern_length <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_length <= cfg_data;
      end
      if (s_tvalid && s_tready) begin
        in_valid <= 1'b1;
      end else if (proc) begin
        in_valid <= 1'b0;
      end
      if (scan && (hit || miss)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      if (scan) begin
        if (in_last) begin
          bytes_seen   <= '0;
          hit_reported <= 1'b0;
        end else begin
          bytes_seen <= bytes_seen_next;
          if (hit) begin
            hit_reported <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd  <= cmd_t'(s_tuser[0]);
      in_idx  <= s_tdata[5:0];
      in_val  <= s_tdata[13:6];
      in_wild <= s_tdata[14];
      in_byte <= s_tdata[22:15];
      in_last <= s_tlast;
    end
    if (scan) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        window[k] <= window_next[k];
      end
      if (hit || miss) begin
        out_found  <= hit;
        out_offset <= hit ? RESULT_W'(offset_full) : '0;
      end
    end
    if (proc && (in_cmd == CMD_LOAD)) begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
        if (32'(in_idx) == 32'(k)) begin
          pat_val[k]  <= in_val;
          pat_wild[k] <= in_wild;
        end
      end
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = out_offset;
  assign m_tuser[0] = out_found;

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("not-found result with nonzero offset");

  a_region_clear: assert property (@(posedge clk) disable iff (rst)
    scan && in_last |=> bytes_seen == '0 && !hit_reported)
    else $error("region end did not clear scan state");

  a_load_keeps_scan: assert property (@(posedge clk) disable iff (rst)
    proc && in_cmd == CMD_LOAD |=> $stable(bytes_seen) && $stable(hit_reported))
    else $error("load item disturbed scan state");

  a_one_hit: assert property (@(posedge clk) disable iff (rst)
    scan && hit_reported |-> !hit)
    else $error("second hit in one region");

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the wildcard byte pattern scanner: stream driver, monitor, predictor.
module tb_top;
  import wbps_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int IDLE_PCT    = 17;

  typedef struct {
    cmd_t                 cmd;
    logic [IDX_W-1:0]     idx;
    byte_t                val;
    logic                 wild;
    byte_t                data;
    logic                 last;
    logic                 hold;
  } scan_item_t;

  typedef struct {
    logic                 found;
    logic [RESULT_W-1:0]  offset;
  } report_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [23:0]         s_tdata = '0;
  logic [0:0]          s_tuser = '0;
  logic                s_tlast = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [RESULT_W-1:0] m_tdata;
  logic [0:0]          m_tuser;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [LEN_W-1:0]    cfg_data = '0;

  wildcard_byte_pattern_scanner_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  byte_t               pat_val  [PATTERN_MAX];
  logic                pat_wild [PATTERN_MAX];
  byte_t               window   [PATTERN_MAX];
  logic [OFFSET_BITS-1:0] seen_count = '0;
  logic                hit_done = 1'b0;
  logic [LEN_W-1:0]    cur_length = '0;

  // generator's view of the pattern
  byte_t               gen_val  [PATTERN_MAX];
  logic                gen_wild [PATTERN_MAX];

  scan_item_t          stream_q[$];
  report_t             awaited_reports[$];
  scan_item_t          cur_item;
  int                  items_queued = 0;
  int                  items_sent = 0;
  int                  mismatches = 0;
  int                  cycles = 0;
  bit                  steady = 1'b0;
  bit                  hold_next = 1'b0;

  task automatic scanner_step(scan_item_t it);
    int      n;
    bit      ok;
    report_t r;
    if (it.cmd == CMD_LOAD) begin
      pat_val[it.idx]  = it.val;
      pat_wild[it.idx] = it.wild;
      return;
    end
    for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
    window[0] = it.data;
    if (seen_count != '1) seen_count++;
    n = (cur_length > PATTERN_MAX) ? PATTERN_MAX : int'(cur_length);
    ok = 1'b0;
    if (!hit_done && n > 0 && seen_count >= n) begin
      ok = 1'b1;
      for (int j = 0; j < n; j++)
        if (!pat_wild[j] && window[n-1-j] != pat_val[j]) ok = 1'b0;
    end
    if (ok) begin
      hit_done = 1'b1;
      r.found  = 1'b1;
      r.offset = RESULT_W'(seen_count - n);
      awaited_reports.push_back(r);
    end else if (it.last && !hit_done) begin
      r.found  = 1'b0;
      r.offset = '0;
      awaited_reports.push_back(r);
    end
    if (it.last) begin
      seen_count = '0;
      hit_done   = 1'b0;
    end
  endtask

  // driver
  always @(posedge clk) begin
    scan_item_t nxt;
    bit go;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        scanner_step(cur_item);
        items_sent++;
      end
      if (!s_tvalid || s_tready) begin
        go = 1'b0;
        if (stream_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT))
          go = !(stream_q[0].hold && awaited_reports.size() != 0);
        if (go) begin
          nxt = stream_q.pop_front();
          cur_item = nxt;
          s_tdata  <= {1'b0, nxt.data, nxt.wild, nxt.val, nxt.idx};
          s_tuser  <= nxt.cmd;
          s_tlast  <= nxt.last;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    report_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_reports.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected item: found=%0d offset=%0d", m_tuser[0], m_tdata);
          mismatches++;
        end else begin
          want = awaited_reports.pop_front();
          if (m_tuser[0] !== want.found || m_tdata !== want.offset) begin
            if (mismatches < 10)
              $display("mismatch: expected found=%0d offset=%0d, got found=%0d offset=%0d",
                       want.found, want.offset, m_tuser[0], m_tdata);
            mismatches++;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic add_item(scan_item_t it);
    it.hold   = hold_next;
    hold_next = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      gen_val[it.idx]  = it.val;
      gen_wild[it.idx] = it.wild;
    end
    stream_q.push_back(it);
    items_queued++;
  endtask

  task automatic push_load(int idx, byte_t val, logic wild);
    scan_item_t it;
    it.cmd  = CMD_LOAD;
    it.idx  = IDX_W'(idx);
    it.val  = val;
    it.wild = wild;
    it.data = byte_t'($urandom);
    it.last = 1'($urandom);
    add_item(it);
  endtask

  task automatic push_byte(byte_t data, logic last);
    scan_item_t it;
    it.cmd  = CMD_SCAN;
    it.idx  = IDX_W'($urandom);
    it.val  = byte_t'($urandom);
    it.wild = 1'($urandom);
    it.data = data;
    it.last = last;
    add_item(it);
  endtask

  function automatic byte_t pick_byte();
    if ($urandom_range(1)) return byte_t'($urandom);
    return gen_val[$urandom_range(PATTERN_MAX - 1)];
  endfunction

  task automatic write_length(int len);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= LEN_W'(len);
    do @(posedge clk); while (!cfg_ready);
    cur_length = LEN_W'(len);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (items_sent != items_queued || awaited_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic random_phase(int len, int budget);
    int n, start, pre, post, cut;
    bit paused;
    byte_t b;
    n = (len > PATTERN_MAX) ? PATTERN_MAX : len;
    start = items_queued;
    paused = 1'b0;
    while (items_queued - start < budget) begin
      if (!paused && items_queued - start > budget / 3) begin
        hold_next = 1'b1;
        paused = 1'b1;
      end
      case ($urandom_range(99)) inside
        [0:9]: begin
          push_load($urandom_range(PATTERN_MAX - 1), byte_t'($urandom), $urandom_range(99) < 25);
        end
        [10:24]: begin
          cut = $urandom_range(1, 8);
          for (int i = 0; i < cut; i++) push_byte(pick_byte(), i == cut - 1);
        end
        default: begin
          if (n == 0) begin
            cut = $urandom_range(1, 12);
            for (int i = 0; i < cut; i++) push_byte(pick_byte(), i == cut - 1);
          end else begin
            pre  = $urandom_range(0, 6);
            post = $urandom_range(0, 4);
            cut  = ($urandom_range(99) < 20) ? $urandom_range(n - 1) : -1;
            for (int i = 0; i < pre; i++) push_byte(pick_byte(), 1'b0);
            for (int j = 0; j < n; j++) begin
              b = gen_wild[j] ? byte_t'($urandom) : gen_val[j];
              if (j == cut) b = ~gen_val[j];
              if ($urandom_range(99) < 3)
                push_load($urandom_range(PATTERN_MAX - 1), byte_t'($urandom),
                          $urandom_range(99) < 25);
              push_byte(b, post == 0 && j == n - 1);
            end
            for (int i = 0; i < post; i++) push_byte(pick_byte(), i == post - 1);
          end
        end
      endcase
    end
  endtask

  initial begin
    int lens[9];
    for (int i = 0; i < PATTERN_MAX; i++) begin
      pat_val[i]  = '0;
      pat_wild[i] = 1'b0;
      window[i]   = '0;
    end
    lens = '{1, 0, 64, 5, 127, 3, 65, 16, $urandom_range(2, 40)};
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    write_length(4);
    // every entry written before any compare can reach it
    for (int i = 0; i < PATTERN_MAX; i++)
      push_load(i, byte_t'($urandom), $urandom_range(99) < 25);
    // directed: extremes, wildcard, hit on last byte, only first hit, short regions
    push_load(0, 8'h00, 1'b0);
    push_load(1, 8'hFF, 1'b0);
    push_load(2, 8'h5A, 1'b1);
    push_load(3, 8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h37, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h11, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hC3, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hA5, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b1);
    drain();

    for (int p = 0; p < 9; p++) begin
      write_length(lens[p]);
      steady = (p == 3);
      random_phase(lens[p], 120);
      drain();
    end
    steady = 1'b0;

    if (mismatches == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
